@@ design/utcld_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and BCD helpers for the UTC to local date and hour converter.
package utcld_pkg;

	// Calendar constants
	localparam logic [4:0] OFFSET_RESET  = 5'd8;
	localparam logic [7:0] HOURS_PER_DAY = 8'd24;
	localparam logic [7:0] CENTURY       = 8'd100;
	localparam logic [7:0] DAYS_28       = 8'd28;
	localparam logic [7:0] DAYS_29       = 8'd29;
	localparam logic [7:0] DAYS_30       = 8'd30;
	localparam logic [7:0] DAYS_31       = 8'd31;

	// Month numbers
	localparam logic [7:0] MONTH_JAN = 8'd1;
	localparam logic [7:0] MONTH_FEB = 8'd2;
	localparam logic [7:0] MONTH_APR = 8'd4;
	localparam logic [7:0] MONTH_JUN = 8'd6;
	localparam logic [7:0] MONTH_SEP = 8'd9;
	localparam logic [7:0] MONTH_NOV = 8'd11;
	localparam logic [7:0] MONTH_DEC = 8'd12;

	// Leading year digits for which the conversion applies
	localparam logic [3:0] LEAD_ONE = 4'd1;
	localparam logic [3:0] LEAD_TWO = 4'd2;

	// Input word
	typedef struct packed {
		logic [15:0] year_digits;
		logic [7:0]  month_digits;
		logic [7:0]  day_digits;
		logic [7:0]  hour_digits;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic        valid_res;
		logic [15:0] local_year;
		logic [7:0]  local_month;
		logic [7:0]  local_day;
		logic [7:0]  local_hour;
	} out_word_t;

	// Decoded fields after the first stage
	typedef struct packed {
		logic       conv;
		in_word_t   raw;
		logic [5:0] yh;    // year / 100
		logic [7:0] yt;    // year % 100, may exceed 99 for out-of-range nibbles
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
	} dec_t;

	// Hour sum and month-end facts after the second stage
	typedef struct packed {
		logic       conv;
		in_word_t   raw;
		logic [5:0] yh;
		logic [7:0] yt;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
		logic       roll;
		logic       last_day;
	} sum_t;

	// Binary local date after the third stage
	typedef struct packed {
		logic       conv;
		in_word_t   raw;
		logic [5:0] yh;
		logic [6:0] yt;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
	} date_t;

	// Two BCD digits to binary, nibbles at face value
	function automatic logic [7:0] bcd2_value(input logic [7:0] d);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = {4'd0, d[7:4]};
		lo = {4'd0, d[3:0]};
		return 8'((hi << 3) + (hi << 1) + lo);
	endfunction

	// Binary to two BCD digits, modulo 100
	function automatic logic [7:0] to_bcd2(input logic [7:0] v);
		logic [7:0] r;
		logic [3:0] tens;
		logic [7:0] units;
		if (v >= 8'd200)
			r = v - 8'd200;
		else if (v >= 8'd100)
			r = v - 8'd100;
		else
			r = v;
		tens = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (r >= 8'(k * 10))
				tens = 4'(k);
		end
		units = r - 8'(({4'd0, tens} << 3) + ({4'd0, tens} << 1));
		return {tens, units[3:0]};
	endfunction

endpackage

@@ design/utc_to_local_date_hour_core.sv @@
`timescale 1ns / 1ps
// Top level of the UTC to local date and hour converter.
// Takes one UTC timestamp word in every cycle in which start is high; busy is always low.
// Each word gives its result as a one-cycle done pulse with local_time, in input order,
// after the four pipeline stages (decode, hour sum and month length, date carry, BCD
// encode); a result must be taken in its done cycle. hour_offset resets to 8 and is
// written through cfg_wr_en and cfg_wr_data; the user must write it only while no word
// is in flight, as the block itself does not enforce this.
module utc_to_local_date_hour_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  utcld_pkg::in_word_t  stamp,
	output logic                 done,
	output utcld_pkg::out_word_t local_time,
	input  logic                 cfg_wr_en,
	input  logic [4:0]           cfg_wr_data
);

	logic [4:0]       offset_q;
	logic             vld_s1;
	logic             vld_s3;
	utcld_pkg::dec_t  dec_s1;
	utcld_pkg::date_t date_s3;

	// Accept a word in every cycle
	assign busy = 1'b0;

	// Hold the hour offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= utcld_pkg::OFFSET_RESET;
		end else begin
			if (cfg_wr_en) begin
				offset_q <= cfg_wr_data;
			end
		end
	end

	utcld_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.in_word (stamp),
		.vld_s1  (vld_s1),
		.dec_s1  (dec_s1)
	);

	utcld_roll u_roll (
		.clk         (clk),
		.arst_n      (arst_n),
		.hour_offset (offset_q),
		.vld_s1      (vld_s1),
		.dec_s1      (dec_s1),
		.vld_s3      (vld_s3),
		.date_s3     (date_s3)
	);

	utcld_encode u_encode (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s3  (vld_s3),
		.date_s3 (date_s3),
		.vld_s4  (done),
		.res_s4  (local_time)
	);

endmodule

@@ design/utcld_decode.sv @@
`timescale 1ns / 1ps
// First stage: BCD fields to binary and check of the leading year digit.
module utcld_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  utcld_pkg::in_word_t in_word,
	output logic                vld_s1,
	output utcld_pkg::dec_t     dec_s1
);

	utcld_pkg::dec_t dec_d;

	// Split the year into century and tail, decode the other fields
	always_comb begin
		dec_d.conv  = (in_word.year_digits[15:12] == utcld_pkg::LEAD_ONE) ||
			(in_word.year_digits[15:12] == utcld_pkg::LEAD_TWO);
		dec_d.raw   = in_word;
		dec_d.yh    = 6'(utcld_pkg::bcd2_value(in_word.year_digits[15:8]));
		dec_d.yt    = utcld_pkg::bcd2_value(in_word.year_digits[7:0]);
		dec_d.month = utcld_pkg::bcd2_value(in_word.month_digits);
		dec_d.day   = utcld_pkg::bcd2_value(in_word.day_digits);
		dec_d.hour  = utcld_pkg::bcd2_value(in_word.hour_digits);
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	// Hold the decoded word
	always_ff @(posedge clk) begin
		dec_s1 <= dec_d;
	end

endmodule

@@ design/utcld_roll.sv @@
`timescale 1ns / 1ps
// Second and third stages: hour sum, month length and the day, month and year carry.
module utcld_roll (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [4:0]        hour_offset,
	input  logic              vld_s1,
	input  utcld_pkg::dec_t   dec_s1,
	output logic              vld_s3,
	output utcld_pkg::date_t  date_s3
);

	utcld_pkg::sum_t  sum_d;
	utcld_pkg::sum_t  sum_s2;
	utcld_pkg::date_t date_d;
	logic             vld_s2;
	logic [7:0]       hsum;
	logic             leap;
	logic [7:0]       last;
	logic             year_inc;
	logic [7:0]       yt_inc;
	logic             cent_carry;

	// Add the offset, find the length of the month
	always_comb begin
		hsum = dec_s1.hour + {3'd0, hour_offset};
		leap = ((dec_s1.yt[1:0] == 2'd0) && (dec_s1.yt != 8'd0) &&
			(dec_s1.yt != utcld_pkg::CENTURY)) ||
			((dec_s1.yt == 8'd0) && (dec_s1.yh[1:0] == 2'd0)) ||
			((dec_s1.yt == utcld_pkg::CENTURY) && (dec_s1.yh[1:0] == 2'b11));
		if (dec_s1.month == utcld_pkg::MONTH_FEB)
			last = leap ? utcld_pkg::DAYS_29 : utcld_pkg::DAYS_28;
		else if ((dec_s1.month == utcld_pkg::MONTH_APR) ||
			(dec_s1.month == utcld_pkg::MONTH_JUN) ||
			(dec_s1.month == utcld_pkg::MONTH_SEP) ||
			(dec_s1.month == utcld_pkg::MONTH_NOV))
			last = utcld_pkg::DAYS_30;
		else
			last = utcld_pkg::DAYS_31;
		sum_d.conv     = dec_s1.conv;
		sum_d.raw      = dec_s1.raw;
		sum_d.yh       = dec_s1.yh;
		sum_d.yt       = dec_s1.yt;
		sum_d.month    = dec_s1.month;
		sum_d.day      = dec_s1.day;
		sum_d.roll     = hsum >= utcld_pkg::HOURS_PER_DAY;
		sum_d.hour     = sum_d.roll ? hsum - utcld_pkg::HOURS_PER_DAY : hsum;
		sum_d.last_day = dec_s1.day == last;
	end

	// Advance the date by one day where the hour rolled over
	always_comb begin
		date_d.conv  = sum_s2.conv;
		date_d.raw   = sum_s2.raw;
		date_d.hour  = sum_s2.hour;
		date_d.month = sum_s2.month;
		date_d.day   = sum_s2.day;
		year_inc     = 1'b0;
		if (sum_s2.roll) begin
			if (sum_s2.last_day) begin
				date_d.day = 8'd1;
				if (sum_s2.month == utcld_pkg::MONTH_DEC) begin
					date_d.month = utcld_pkg::MONTH_JAN;
					year_inc     = 1'b1;
				end else begin
					date_d.month = sum_s2.month + 8'd1;
				end
			end else begin
				date_d.day = sum_s2.day + 8'd1;
			end
		end
		// Fold the year tail back below one hundred
		yt_inc     = sum_s2.yt + {7'd0, year_inc};
		cent_carry = yt_inc >= utcld_pkg::CENTURY;
		date_d.yh  = sum_s2.yh + {5'd0, cent_carry};
		date_d.yt  = cent_carry ? 7'(yt_inc - utcld_pkg::CENTURY) : yt_inc[6:0];
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Hold the stage words
	always_ff @(posedge clk) begin
		sum_s2  <= sum_d;
		date_s3 <= date_d;
	end

endmodule

@@ design/utcld_encode.sv @@
`timescale 1ns / 1ps
// Fourth stage: binary local date back to BCD, or the input word passed through.
module utcld_encode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_s3,
	input  utcld_pkg::date_t     date_s3,
	output logic                 vld_s4,
	output utcld_pkg::out_word_t res_s4
);

	utcld_pkg::out_word_t res_d;

	// Encode the converted fields, or copy the input where no conversion applies
	always_comb begin
		res_d.valid_res = date_s3.conv;
		if (date_s3.conv) begin
			res_d.local_year  = {utcld_pkg::to_bcd2({2'd0, date_s3.yh}),
				utcld_pkg::to_bcd2({1'b0, date_s3.yt})};
			res_d.local_month = utcld_pkg::to_bcd2(date_s3.month);
			res_d.local_day   = utcld_pkg::to_bcd2(date_s3.day);
			res_d.local_hour  = utcld_pkg::to_bcd2(date_s3.hour);
		end else begin
			res_d.local_year  = date_s3.raw.year_digits;
			res_d.local_month = date_s3.raw.month_digits;
			res_d.local_day   = date_s3.raw.day_digits;
			res_d.local_hour  = date_s3.raw.hour_digits;
		end
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	// Hold the result word
	always_ff @(posedge clk) begin
		res_s4 <= res_d;
	end

endmodule

@@ design/utcld_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the converter, bound to the top level.
module utcld_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input utcld_pkg::in_word_t  stamp,
	input logic                 done,
	input utcld_pkg::out_word_t local_time
);

	// Every accepted word gives its result on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted word gave no result after four cycles");

	// No result without an earlier accepted word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without an accepted word");

	// Conversion flag follows the leading year digit
	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (local_time.valid_res ==
			(($past(stamp.year_digits[15:12], 4) == utcld_pkg::LEAD_ONE) ||
			($past(stamp.year_digits[15:12], 4) == utcld_pkg::LEAD_TWO))))
		else $error("valid_res does not match the leading year digit");

	// Unconverted words pass through unchanged
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !local_time.valid_res) |->
			(local_time.local_year == $past(stamp.year_digits, 4)) &&
			(local_time.local_hour == $past(stamp.hour_digits, 4)))
		else $error("unconverted word not passed through");

	// Converted hour is always proper BCD
	a_hour_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && local_time.valid_res) |->
			(local_time.local_hour[3:0] <= 4'd9) && (local_time.local_hour[7:4] <= 4'd9))
		else $error("local hour is not BCD");

endmodule

bind utc_to_local_date_hour_core utcld_checker u_utcld_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.stamp      (stamp),
	.done       (done),
	.local_time (local_time)
);
